/* rtl/gmd_pkg.sv */
// Shared types and constants of the grid maze depth-first depth map.
`default_nettype none

package gmd_pkg;

    localparam int KIND_W   = 2;
    localparam int COORD_IN_W = 6;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_SOLVE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    localparam logic [STATUS_W-1:0] STATUS_READ    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXIT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_PATH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_READ,
        S_LOOP,
        S_TRY,
        S_CHK,
        S_DEAD,
        S_POP,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [COORD_IN_W-1:0] row;
        logic [COORD_IN_W-1:0] col;
        logic                  open;
    } t_cmd;

    typedef struct packed {
        logic                       valid;
        logic [STATUS_W-1:0]        status;
        logic signed [DEPTH_W-1:0]  depth;
    } t_result;

endpackage

`default_nettype wire

/* rtl/gmd_walk.sv */
// Cell and stack memories with the load, read, clear and depth-first walk sequencer.
`default_nettype none

module gmd_walk #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [$clog2(MAX_SIDE+1)-1:0]    i_grid_width,
    input  wire logic [$clog2(MAX_SIDE+1)-1:0]    i_grid_height,
    input  wire logic                             i_cmd_valid,
    output logic                                  o_cmd_ready,
    input  wire gmd_pkg::t_cmd                    i_cmd,
    output gmd_pkg::t_result                      o_res,
    input  wire logic                             i_res_ready
);

    localparam int CW     = $clog2(MAX_SIDE);
    localparam int SW     = $clog2(MAX_SIDE + 1);
    localparam int XW     = (SW > 7) ? SW : 7;
    localparam int AW     = 2 * CW;
    localparam int NCELL  = 1 << AW;
    localparam int DW     = $clog2(NCELL + 1);
    localparam int NSTACK = MAX_SIDE * MAX_SIDE;
    localparam int SKW    = $clog2(NSTACK);
    localparam int KW     = $clog2(NSTACK + 1);
    localparam int EW     = 2 * CW + DW;

    localparam logic [AW:0] ClrEnd   = (AW+1)'(NCELL);
    localparam logic [KW-1:0] StackMax = KW'(NSTACK);

    logic [DW:0]   r_cell_mem  [NCELL];
    logic [EW-1:0] r_stack_mem [NSTACK];

    gmd_pkg::t_state r_state, n_state;
    logic [AW:0]     r_clr_idx, n_clr_idx;
    logic            r_solve, n_solve;
    logic [CW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [DW-1:0]   r_depth, n_depth;
    logic [KW-1:0]   r_count, n_count;
    logic [1:0]      r_dir, n_dir;

    logic [CW-1:0]   r_start_row, n_start_row;
    logic [CW-1:0]   r_start_col, n_start_col;
    logic [CW-1:0]   r_nrow, n_nrow;
    logic [CW-1:0]   r_ncol, n_ncol;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_ld_open, n_ld_open;
    logic            r_in_grid, n_in_grid;
    logic [gmd_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [gmd_pkg::DEPTH_W-1:0]  r_res_depth, n_res_depth;

    logic            r_rd_open;
    logic [DW-1:0]   r_rd_depth;
    logic [EW-1:0]   r_stk_rdata;

    logic            cell_rd_en;
    logic [AW-1:0]   cell_rd_addr;
    logic            cell_wr_en;
    logic [AW-1:0]   cell_wr_addr;
    logic            cell_wr_open;
    logic [DW-1:0]   cell_wr_depth;
    logic            stk_rd_en;
    logic [SKW-1:0]  stk_rd_addr;
    logic            stk_wr_en;
    logic [SKW-1:0]  stk_wr_addr;
    logic [EW-1:0]   stk_wr_data;

    logic [AW:0]     clr_dec;
    logic [AW-1:0]   clr_prev;
    logic [AW-1:0]   start_addr;
    logic [AW-1:0]   cmd_addr;
    logic            cmd_in_store;
    logic            cmd_in_grid;
    logic [SW-1:0]   h_m1;
    logic [SW-1:0]   w_m1;
    logic [CW:0]     row_p1;
    logic [CW:0]     col_p1;
    logic            nb_ok;
    logic [CW-1:0]   nb_row;
    logic [CW-1:0]   nb_col;
    logic            move_ok;
    logic [DW-1:0]   depth_p1;
    logic [KW-1:0]   cnt_m2;
    logic [DW-1:0]   pop_depth;

    always_comb begin
        clr_dec      = r_clr_idx - 1'b1;
        clr_prev     = clr_dec[AW-1:0];
        start_addr   = {r_start_row, r_start_col};
        cmd_addr     = {CW'(i_cmd.row), CW'(i_cmd.col)};
        cmd_in_store = (XW'(i_cmd.row) < XW'(MAX_SIDE)) && (XW'(i_cmd.col) < XW'(MAX_SIDE));
        cmd_in_grid  = (XW'(i_cmd.row) < XW'(i_grid_height))
                    && (XW'(i_cmd.col) < XW'(i_grid_width));
        h_m1         = i_grid_height - 1'b1;
        w_m1         = i_grid_width - 1'b1;
        row_p1       = {1'b0, r_row} + 1'b1;
        col_p1       = {1'b0, r_col} + 1'b1;
        depth_p1     = r_depth + 1'b1;
        cnt_m2       = r_count - KW'(2);
        move_ok      = (r_state == gmd_pkg::S_CHK) && r_rd_open && (r_rd_depth == '0);
        pop_depth    = r_stk_rdata[DW-1:0];
    end

    always_comb begin
        nb_row = r_row;
        nb_col = r_col;
        nb_ok  = 1'b0;
        case (r_dir)
            gmd_pkg::DIR_RIGHT: begin
                nb_col = col_p1[CW-1:0];
                nb_ok  = XW'(col_p1) < XW'(i_grid_width);
            end
            gmd_pkg::DIR_DOWN: begin
                nb_row = row_p1[CW-1:0];
                nb_ok  = XW'(row_p1) < XW'(i_grid_height);
            end
            gmd_pkg::DIR_LEFT: begin
                nb_col = r_col - 1'b1;
                nb_ok  = r_col != '0;
            end
            default: begin
                nb_row = r_row - 1'b1;
                nb_ok  = r_row != '0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_solve      = r_solve;
        n_row        = r_row;
        n_col        = r_col;
        n_depth      = r_depth;
        n_count      = r_count;
        n_dir        = r_dir;
        n_start_row  = r_start_row;
        n_start_col  = r_start_col;
        n_nrow       = r_nrow;
        n_ncol       = r_ncol;
        n_addr       = r_addr;
        n_ld_open    = r_ld_open;
        n_in_grid    = r_in_grid;
        n_res_status = r_res_status;
        n_res_depth  = r_res_depth;

        cell_rd_en    = 1'b0;
        cell_rd_addr  = '0;
        cell_wr_en    = 1'b0;
        cell_wr_addr  = '0;
        cell_wr_open  = 1'b0;
        cell_wr_depth = '0;
        stk_rd_en     = 1'b0;
        stk_rd_addr   = '0;
        stk_wr_en     = 1'b0;
        stk_wr_addr   = '0;
        stk_wr_data   = '0;

        o_cmd_ready  = 1'b0;
        o_res.valid  = 1'b0;
        o_res.status = r_res_status;
        o_res.depth  = r_res_depth;

        case (r_state)
            gmd_pkg::S_CLEAR: begin
                if (r_clr_idx != ClrEnd) begin
                    cell_rd_en   = 1'b1;
                    cell_rd_addr = r_clr_idx[AW-1:0];
                end
                if (r_clr_idx != '0) begin
                    cell_wr_en    = 1'b1;
                    cell_wr_addr  = clr_prev;
                    cell_wr_open  = r_rd_open;
                    cell_wr_depth = (r_solve && clr_prev == start_addr) ? DW'(1) : '0;
                end
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == ClrEnd) begin
                    n_clr_idx = '0;
                    n_state   = r_solve ? gmd_pkg::S_LOOP : gmd_pkg::S_IDLE;
                end
            end
            gmd_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        gmd_pkg::KIND_LOAD: begin
                            if (cmd_in_store) begin
                                cell_rd_en   = 1'b1;
                                cell_rd_addr = cmd_addr;
                                n_addr       = cmd_addr;
                                n_ld_open    = i_cmd.open;
                                n_state      = gmd_pkg::S_LOAD;
                            end
                        end
                        gmd_pkg::KIND_SOLVE: begin
                            n_start_row = h_m1[CW-1:0];
                            n_start_col = w_m1[CW-1:0];
                            n_row       = h_m1[CW-1:0];
                            n_col       = w_m1[CW-1:0];
                            n_depth     = DW'(1);
                            n_count     = '0;
                            n_solve     = 1'b1;
                            n_clr_idx   = '0;
                            n_state     = gmd_pkg::S_CLEAR;
                        end
                        gmd_pkg::KIND_READ: begin
                            n_in_grid = cmd_in_grid;
                            if (cmd_in_grid) begin
                                cell_rd_en   = 1'b1;
                                cell_rd_addr = cmd_addr;
                            end
                            n_state = gmd_pkg::S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            gmd_pkg::S_LOAD: begin
                cell_wr_en    = 1'b1;
                cell_wr_addr  = r_addr;
                cell_wr_open  = r_ld_open;
                cell_wr_depth = r_rd_depth;
                n_state       = gmd_pkg::S_IDLE;
            end
            gmd_pkg::S_READ: begin
                n_res_status = gmd_pkg::STATUS_READ;
                n_res_depth  = (r_in_grid && r_rd_depth != '0) ?
                               gmd_pkg::DEPTH_W'(r_rd_depth) : '1;
                n_state      = gmd_pkg::S_RESULT;
            end
            gmd_pkg::S_LOOP: begin
                if (r_row == '0 && r_col == '0) begin
                    n_res_status = gmd_pkg::STATUS_EXIT;
                    n_res_depth  = '0;
                    n_state      = gmd_pkg::S_RESULT;
                end else begin
                    n_dir   = gmd_pkg::DIR_RIGHT;
                    n_state = gmd_pkg::S_TRY;
                end
            end
            gmd_pkg::S_TRY: begin
                if (nb_ok) begin
                    cell_rd_en   = 1'b1;
                    cell_rd_addr = {nb_row, nb_col};
                    n_nrow       = nb_row;
                    n_ncol       = nb_col;
                    n_state      = gmd_pkg::S_CHK;
                end else if (r_dir == gmd_pkg::DIR_UP) begin
                    n_state = gmd_pkg::S_DEAD;
                end else begin
                    n_dir = r_dir + 2'd1;
                end
            end
            gmd_pkg::S_CHK: begin
                if (move_ok) begin
                    cell_wr_en    = 1'b1;
                    cell_wr_addr  = {r_nrow, r_ncol};
                    cell_wr_open  = 1'b1;
                    cell_wr_depth = depth_p1;
                    n_row         = r_nrow;
                    n_col         = r_ncol;
                    n_depth       = depth_p1;
                    if (r_count < StackMax) begin
                        stk_wr_en   = 1'b1;
                        stk_wr_addr = r_count[SKW-1:0];
                        stk_wr_data = {r_nrow, r_ncol, depth_p1};
                        n_count     = r_count + 1'b1;
                    end
                    n_state = gmd_pkg::S_LOOP;
                end else if (r_dir == gmd_pkg::DIR_UP) begin
                    n_state = gmd_pkg::S_DEAD;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = gmd_pkg::S_TRY;
                end
            end
            gmd_pkg::S_DEAD: begin
                if (r_row == r_start_row && r_col == r_start_col) begin
                    n_res_status = gmd_pkg::STATUS_NO_PATH;
                    n_res_depth  = '0;
                    n_state      = gmd_pkg::S_RESULT;
                end else if (r_count < KW'(2)) begin
                    n_row   = r_start_row;
                    n_col   = r_start_col;
                    n_depth = DW'(1);
                    n_count = '0;
                    n_state = gmd_pkg::S_LOOP;
                end else begin
                    stk_rd_en   = 1'b1;
                    stk_rd_addr = cnt_m2[SKW-1:0];
                    n_state     = gmd_pkg::S_POP;
                end
            end
            gmd_pkg::S_POP: begin
                n_row   = r_stk_rdata[EW-1 -: CW];
                n_col   = r_stk_rdata[EW-CW-1 -: CW];
                n_depth = pop_depth;
                n_count = r_count - 1'b1;
                n_state = gmd_pkg::S_LOOP;
            end
            gmd_pkg::S_RESULT: begin
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_solve = 1'b0;
                    n_state = gmd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gmd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gmd_pkg::S_CLEAR;
            r_clr_idx <= '0;
            r_solve   <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_depth   <= DW'(1);
            r_count   <= '0;
            r_dir     <= gmd_pkg::DIR_RIGHT;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_solve   <= n_solve;
            r_row     <= n_row;
            r_col     <= n_col;
            r_depth   <= n_depth;
            r_count   <= n_count;
            r_dir     <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start_row  <= n_start_row;
        r_start_col  <= n_start_col;
        r_nrow       <= n_nrow;
        r_ncol       <= n_ncol;
        r_addr       <= n_addr;
        r_ld_open    <= n_ld_open;
        r_in_grid    <= n_in_grid;
        r_res_status <= n_res_status;
        r_res_depth  <= n_res_depth;
    end

    always_ff @(posedge i_clk) begin
        if (cell_wr_en) begin
            r_cell_mem[cell_wr_addr] <= {cell_wr_open, cell_wr_depth};
        end
        if (cell_rd_en) begin
            {r_rd_open, r_rd_depth} <= r_cell_mem[cell_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_wr_en) begin
            r_stack_mem[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en) begin
            r_stk_rdata <= r_stack_mem[stk_rd_addr];
        end
    end

    a_pop_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmd_pkg::S_POP) |-> (r_count >= KW'(2)))
        else $error("Stack pop with fewer than two entries.");

    a_move_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move_ok |=> (r_depth == $past(depth_p1)))
        else $error("Depth did not advance by one on a step.");

    a_walk_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmd_pkg::S_TRY) |->
            ((XW'(r_row) < XW'(i_grid_height)) && (XW'(r_col) < XW'(i_grid_width))))
        else $error("Walk position left the grid.");

    a_ready_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> !o_res.valid)
        else $error("Request taken while a result is pending.");

endmodule

`default_nettype wire

/* rtl/grid_maze_dfs_depth_map.sv */
// Top level: grid size registers, request intake and the result output register.
// Load: the cell is read while idle and written back in the load state. Read: idle,
// read and result states lead to the result register. Kind 3 is taken and dropped.
// Solve: a clearing pass over the cell memory, then per position the loop state, try
// and check per in-grid neighbor, try per off-grid one, dead per dead end and pop per stack pop, then result.
// One request is in work at a time; the result register frees the sequencer early.
// After reset the same clearing pass runs before the first request is taken.
`default_nettype none

module grid_maze_dfs_depth_map #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [gmd_pkg::KIND_W-1:0]            i_kind,
    input  wire logic [gmd_pkg::COORD_IN_W-1:0]        i_row,
    input  wire logic [gmd_pkg::COORD_IN_W-1:0]        i_col,
    input  wire logic                                  i_open,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [gmd_pkg::STATUS_W-1:0]               o_status,
    output logic signed [gmd_pkg::DEPTH_W-1:0]         o_depth,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [gmd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [gmd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int SW        = $clog2(MAX_SIDE + 1);
    localparam int XW        = (SW > 7) ? SW : 7;
    localparam int ResetSide = (64 > MAX_SIDE) ? MAX_SIDE : 64;

    logic [SW-1:0] r_grid_width, n_grid_width;
    logic [SW-1:0] r_grid_height, n_grid_height;
    logic [SW-1:0] cfg_side;
    logic [XW-1:0] cfg_ext;

    logic                          r_out_valid, n_out_valid;
    logic [gmd_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic [gmd_pkg::DEPTH_W-1:0]   r_out_depth, n_out_depth;

    gmd_pkg::t_cmd    cmd;
    gmd_pkg::t_result res;
    logic             res_ready;

    always_comb begin
        cfg_ext = XW'(i_cfg_data);
        if (cfg_ext == '0) begin
            cfg_side = SW'(1);
        end else if (cfg_ext > XW'(MAX_SIDE)) begin
            cfg_side = SW'(MAX_SIDE);
        end else begin
            cfg_side = SW'(cfg_ext);
        end
        n_grid_width  = r_grid_width;
        n_grid_height = r_grid_height;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                gmd_pkg::CFG_GRID_WIDTH:  n_grid_width  = cfg_side;
                gmd_pkg::CFG_GRID_HEIGHT: n_grid_height = cfg_side;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        res_ready    = !r_out_valid || i_out_ready;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_depth  = r_out_depth;
        if (res.valid && res_ready) begin
            n_out_valid  = 1'b1;
            n_out_status = res.status;
            n_out_depth  = res.depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= SW'(ResetSide);
            r_grid_height <= SW'(ResetSide);
            r_out_valid   <= 1'b0;
        end else begin
            r_grid_width  <= n_grid_width;
            r_grid_height <= n_grid_height;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_depth  <= n_out_depth;
    end

    assign cmd.kind = i_kind;
    assign cmd.row  = i_row;
    assign cmd.col  = i_col;
    assign cmd.open = i_open;

    gmd_walk #(
        .MAX_SIDE (MAX_SIDE)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_cmd_valid   (i_in_valid),
        .o_cmd_ready   (o_in_ready),
        .i_cmd         (cmd),
        .o_res         (res),
        .i_res_ready   (res_ready)
    );

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_depth     = r_out_depth;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Testbench for grid_maze_dfs_depth_map: random mazes and grid sizes, with result checking.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE = 64;
    localparam int CELL_COUNT = SIDE * SIDE;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int ITEM_TARGET = 500;
    localparam logic [gmd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [gmd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [gmd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [gmd_pkg::STATUS_W-1:0]       status;
        logic signed [gmd_pkg::DEPTH_W-1:0] depth;
    } t_answer;

    class maze_depth_checker;
        bit       open_cell[CELL_COUNT];
        int       depth_cell[CELL_COUNT];
        int       trail_row[CELL_COUNT];
        int       trail_col[CELL_COUNT];
        int       trail_depth[CELL_COUNT];
        int       grid_w;
        int       grid_h;
        t_answer  answers_due[$];
        int       errors;

        function void reset_model();
            grid_w = SIDE;
            grid_h = SIDE;
            errors = 0;
            answers_due.delete();
            foreach (open_cell[i]) open_cell[i] = 1'b0;
            foreach (depth_cell[i]) depth_cell[i] = -1;
        endfunction

        function int clamp_side(logic [gmd_pkg::CFG_DATA_W-1:0] value);
            if (value == 0) return 1;
            if (value > SIDE) return SIDE;
            return int'(value);
        endfunction

        function void write_register(logic [gmd_pkg::CFG_IDX_W-1:0] index,
                                     logic [gmd_pkg::CFG_DATA_W-1:0] value);
            case (index)
                gmd_pkg::CFG_GRID_WIDTH:  grid_w = clamp_side(value);
                gmd_pkg::CFG_GRID_HEIGHT: grid_h = clamp_side(value);
                default: ;
            endcase
        endfunction

        function logic [gmd_pkg::STATUS_W-1:0] walk_maze();
            int start_r;
            int start_c;
            int cur_r;
            int cur_c;
            int cur_depth;
            int stacked;
            int next_r;
            int next_c;
            int k;
            bit moved;
            start_r = grid_h - 1;
            start_c = grid_w - 1;
            foreach (depth_cell[i]) depth_cell[i] = -1;
            stacked = 0;
            cur_r = start_r;
            cur_c = start_c;
            cur_depth = 1;
            depth_cell[start_r * SIDE + start_c] = 1;
            while (cur_r != 0 || cur_c != 0) begin
                moved = 1'b0;
                for (k = 0; k < 4 && !moved; k++) begin
                    next_r = cur_r;
                    next_c = cur_c;
                    case (k)
                        gmd_pkg::DIR_RIGHT: next_c = cur_c + 1;
                        gmd_pkg::DIR_DOWN:  next_r = cur_r + 1;
                        gmd_pkg::DIR_LEFT:  next_c = cur_c - 1;
                        default:            next_r = cur_r - 1;
                    endcase
                    if (next_r >= 0 && next_r < grid_h && next_c >= 0 && next_c < grid_w) begin
                        if (open_cell[next_r * SIDE + next_c] &&
                            depth_cell[next_r * SIDE + next_c] == -1) begin
                            cur_r = next_r;
                            cur_c = next_c;
                            moved = 1'b1;
                        end
                    end
                end
                if (moved) begin
                    cur_depth++;
                    depth_cell[cur_r * SIDE + cur_c] = cur_depth;
                    if (stacked < CELL_COUNT) begin
                        trail_row[stacked] = cur_r;
                        trail_col[stacked] = cur_c;
                        trail_depth[stacked] = cur_depth;
                        stacked++;
                    end
                end else if (cur_r == start_r && cur_c == start_c) begin
                    return gmd_pkg::STATUS_NO_PATH;
                end else if (stacked < 2) begin
                    cur_r = start_r;
                    cur_c = start_c;
                    cur_depth = 1;
                    stacked = 0;
                end else begin
                    cur_r = trail_row[stacked - 2];
                    cur_c = trail_col[stacked - 2];
                    cur_depth = trail_depth[stacked - 2];
                    stacked--;
                end
            end
            return gmd_pkg::STATUS_EXIT;
        endfunction

        function void note_request(logic [gmd_pkg::KIND_W-1:0] kind,
                                   logic [gmd_pkg::COORD_IN_W-1:0] row,
                                   logic [gmd_pkg::COORD_IN_W-1:0] col, logic is_open);
            t_answer answer;
            case (kind)
                gmd_pkg::KIND_LOAD: open_cell[row * SIDE + col] = is_open;
                gmd_pkg::KIND_SOLVE: begin
                    answer.status = walk_maze();
                    answer.depth = '0;
                    answers_due.push_back(answer);
                end
                gmd_pkg::KIND_READ: begin
                    answer.status = gmd_pkg::STATUS_READ;
                    answer.depth = '1;
                    if (row < grid_h && col < grid_w) begin
                        answer.depth = gmd_pkg::DEPTH_W'(depth_cell[row * SIDE + col]);
                    end
                    answers_due.push_back(answer);
                end
                default: ;
            endcase
        endfunction

        function void flag(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_result(logic [gmd_pkg::STATUS_W-1:0] status,
                                   logic signed [gmd_pkg::DEPTH_W-1:0] depth);
            t_answer due;
            if (answers_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual status %0d depth %0d",
                         $time, status, depth);
                return;
            end
            due = answers_due.pop_front();
            if (status !== due.status) flag("status", int'(due.status), int'(status));
            if (depth !== due.depth) flag("depth", int'(due.depth), int'(depth));
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic                                   clk;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_ready;
    logic [gmd_pkg::KIND_W-1:0]             in_kind = gmd_pkg::KIND_LOAD;
    logic [gmd_pkg::COORD_IN_W-1:0]         in_row = '0;
    logic [gmd_pkg::COORD_IN_W-1:0]         in_col = '0;
    logic                                   in_open = 1'b0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic [gmd_pkg::STATUS_W-1:0]           out_status;
    logic signed [gmd_pkg::DEPTH_W-1:0]     out_depth;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [gmd_pkg::CFG_IDX_W-1:0]          cfg_index = gmd_pkg::CFG_GRID_WIDTH;
    logic [gmd_pkg::CFG_DATA_W-1:0]         cfg_data = '0;

    maze_depth_checker depth_model;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int items_sent = 0;

    grid_maze_dfs_depth_map u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_kind      (in_kind),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_open      (in_open),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_status    (out_status),
        .o_depth     (out_depth),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #16_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_request(input logic [gmd_pkg::KIND_W-1:0] kind,
                                input int row, input int col, input logic is_open);
        int gap;
        logic [gmd_pkg::COORD_IN_W-1:0] row_v;
        logic [gmd_pkg::COORD_IN_W-1:0] col_v;
        row_v = gmd_pkg::COORD_IN_W'(row);
        col_v = gmd_pkg::COORD_IN_W'(col);
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind <= kind;
        in_row <= row_v;
        in_col <= col_v;
        in_open <= is_open;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        depth_model.note_request(kind, row_v, col_v, is_open);
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (depth_model.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [gmd_pkg::CFG_IDX_W-1:0] index,
                                  input logic [gmd_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        depth_model.write_register(index, value);
        cfg_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
    endtask

    // Sizes at the ends of the range are sometimes written as out-of-range codes.
    function automatic logic [gmd_pkg::CFG_DATA_W-1:0] side_code(int side);
        if (side == 1 && $urandom_range(0, 1) == 1) return '0;
        if (side == SIDE && $urandom_range(0, 1) == 1) begin
            return gmd_pkg::CFG_DATA_W'($urandom_range(65, 127));
        end
        return gmd_pkg::CFG_DATA_W'(side);
    endfunction

    task automatic set_grid(input int w, input int h);
        settle();
        if ($urandom_range(0, 1) == 1) begin
            write_register(gmd_pkg::CFG_GRID_WIDTH, side_code(w));
            write_register(gmd_pkg::CFG_GRID_HEIGHT, side_code(h));
        end else begin
            write_register(gmd_pkg::CFG_GRID_HEIGHT, side_code(h));
            write_register(gmd_pkg::CFG_GRID_WIDTH, side_code(w));
        end
        if ($urandom_range(0, 3) == 0) begin
            write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                           gmd_pkg::CFG_DATA_W'($urandom_range(0, 127)));
        end
    endtask

    // Every cell of the grid in use is loaded before the first solve of a maze.
    task automatic run_maze(input int w, input int h, input int n_mixed);
        int open_pct;
        int pick;
        set_grid(w, h);
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        open_pct = $urandom_range(55, 90);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                send_request(gmd_pkg::KIND_LOAD, r, c, $urandom_range(0, 99) < open_pct);
            end
        end
        send_request(gmd_pkg::KIND_SOLVE, $urandom, $urandom, 1'($urandom));
        for (int k = 0; k < n_mixed; k++) begin
            if (k == n_mixed / 2 && $urandom_range(0, 1) == 1) settle();
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_request(gmd_pkg::KIND_READ, $urandom_range(0, h - 1),
                             $urandom_range(0, w - 1), 1'($urandom));
            end else if (pick < 50) begin
                send_request(gmd_pkg::KIND_READ, $urandom, $urandom, 1'($urandom));
            end else if (pick < 75) begin
                send_request(gmd_pkg::KIND_LOAD, $urandom_range(0, h - 1),
                             $urandom_range(0, w - 1), $urandom_range(0, 99) < open_pct);
            end else if (pick < 82) begin
                send_request(gmd_pkg::KIND_LOAD, $urandom, $urandom, 1'($urandom));
            end else if (pick < 94) begin
                send_request(gmd_pkg::KIND_SOLVE, $urandom, $urandom, 1'($urandom));
            end else begin
                send_request(KIND_UNUSED, $urandom, $urandom, 1'($urandom));
            end
        end
    endtask

    initial begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            depth_model.check_result(out_status, out_depth);
        end
    end

    initial begin
        int w;
        int h;
        depth_model = new;
        depth_model.reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(gmd_pkg::KIND_READ, 0, 0, 1'b0);
        send_request(gmd_pkg::KIND_READ, 63, 63, 1'b1);
        send_request(KIND_UNUSED, $urandom, $urandom, 1'($urandom));
        settle();
        write_register(gmd_pkg::CFG_GRID_WIDTH, 7'd0);
        write_register(gmd_pkg::CFG_GRID_HEIGHT, 7'd2);
        write_register(CFG_SPARE_A, 7'h7F);
        write_register(CFG_SPARE_B, 7'h55);
        send_request(gmd_pkg::KIND_LOAD, 0, 0, 1'b1);
        send_request(gmd_pkg::KIND_LOAD, 1, 0, 1'b0);
        send_request(gmd_pkg::KIND_SOLVE, 0, 0, 1'b0);
        send_request(gmd_pkg::KIND_READ, 1, 0, 1'b0);
        send_request(gmd_pkg::KIND_READ, 0, 0, 1'b0);
        send_request(gmd_pkg::KIND_READ, 0, 1, 1'b0);
        send_request(gmd_pkg::KIND_LOAD, 0, 0, 1'b0);
        send_request(gmd_pkg::KIND_SOLVE, 63, 63, 1'b1);
        send_request(gmd_pkg::KIND_READ, 1, 0, 1'b0);
        send_request(gmd_pkg::KIND_READ, 0, 0, 1'b0);
        settle();
        write_register(gmd_pkg::CFG_GRID_HEIGHT, 7'd1);
        send_request(gmd_pkg::KIND_SOLVE, 0, 0, 1'b0);
        send_request(gmd_pkg::KIND_READ, 0, 0, 1'b0);
        send_request(gmd_pkg::KIND_READ, 63, 63, 1'b0);
        send_request(gmd_pkg::KIND_LOAD, 63, 63, 1'b1);
        settle();
        write_register(gmd_pkg::CFG_GRID_WIDTH, 7'd127);
        write_register(gmd_pkg::CFG_GRID_HEIGHT, 7'd64);
        send_request(gmd_pkg::KIND_READ, 63, 63, 1'b0);
        send_request(gmd_pkg::KIND_READ, 0, 0, 1'b1);

        run_maze(SIDE, 1, $urandom_range(20, 60));
        run_maze(1, SIDE, $urandom_range(20, 60));
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: begin
                    w = SIDE;
                    h = $urandom_range(1, 2);
                end
                1: begin
                    w = $urandom_range(1, 2);
                    h = SIDE;
                end
                default: begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 8);
                end
            endcase
            run_maze(w, h, $urandom_range(20, 60));
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (depth_model.errors == 0 && depth_model.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
